// ===== rtl/pbdc_pkg.sv =====
// package: shared types and constants of the pixel bit depth converter
`timescale 1ns / 1ps
`default_nettype none
package pbdc_pkg;

	// source format codes
	localparam logic [2:0] SRC_1BPP  = 3'd0;
	localparam logic [2:0] SRC_8BPP  = 3'd1;
	localparam logic [2:0] SRC_16BPP = 3'd2;
	localparam logic [2:0] SRC_24BPP = 3'd3;
	localparam logic [2:0] SRC_32BPP = 3'd4;

	// target format codes
	localparam logic [1:0] DST_8BPP  = 2'd0;
	localparam logic [1:0] DST_24BPP = 2'd1;
	localparam logic [1:0] DST_32BPP = 2'd2;

	// configuration register indexes
	localparam logic CFG_SRC_FORMAT = 1'b0;
	localparam logic CFG_DST_FORMAT = 1'b1;

	// gray weights, sum of the three is 2^15
	localparam logic [14:0] GRAY_KR = 15'd9798;
	localparam logic [14:0] GRAY_KG = 15'd19235;
	localparam logic [14:0] GRAY_KB = 15'd3735;

	typedef struct packed {
		logic [2:0] src;
		logic [1:0] dst;
	} cfg_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] a;
		logic       last;
	} pix_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
		logic v_s3;
	} pipe_stat_t;

	// unknown source or target format: bytes go out raw
	function automatic logic cfg_refused(input cfg_t cfg);
		return (cfg.dst > DST_32BPP) || (cfg.src > SRC_32BPP);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pbdc_ifs.sv =====
// interfaces: input pixel channel and output pixel channel
`timescale 1ns / 1ps
`default_nettype none
interface pbdc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_b;
	logic [7:0] byte_g;
	logic [7:0] byte_r;
	logic [7:0] byte_a;
	logic [3:0] bit_count;

	modport source (output valid, output byte_b, output byte_g, output byte_r,
		output byte_a, output bit_count, input ready);
	modport sink (input valid, input byte_b, input byte_g, input byte_r,
		input byte_a, input bit_count, output ready);
endinterface

interface pbdc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_b;
	logic [7:0] out_g;
	logic [7:0] out_r;
	logic [7:0] out_a;
	logic       last;

	modport source (output valid, output out_b, output out_g, output out_r,
		output out_a, output last, input ready);
	modport sink (input valid, input out_b, input out_g, input out_r,
		input out_a, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/pbdc_expand.sv =====
// front stage: holds one input item and issues one pixel per cycle while pix_ready is high
`timescale 1ns / 1ps
`default_nettype none
module pbdc_expand import pbdc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_b,
	input  wire logic [7:0] byte_g,
	input  wire logic [7:0] byte_r,
	input  wire logic [7:0] byte_a,
	input  wire logic [3:0] bit_count,
	output logic            pix_valid,
	input  wire logic       pix_ready,
	output pix_t            pix
);

	logic       busy_q;
	logic [2:0] idx_q;
	logic [3:0] cnt_q;
	logic [7:0] b_q, g_q, r_q, a_q;
	logic       last_pix;
	logic       in_take;
	logic [3:0] cnt_sat;
	logic       bit_v;
	logic [7:0] v;

	assign last_pix  = ({1'b0, idx_q} + 4'd1) == cnt_q;
	assign pix_valid = busy_q;
	assign in_ready  = !busy_q || (pix_ready && last_pix);
	assign in_take   = in_valid && in_ready;

	// zero counts as one pixel, above eight saturates
	always_comb begin
		if (bit_count == 4'd0) begin
			cnt_sat = 4'd1;
		end else if (bit_count > 4'd8) begin
			cnt_sat = 4'd8;
		end else begin
			cnt_sat = bit_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
			cnt_q  <= 4'd1;
		end else if (in_take) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
			cnt_q  <= (cfg.src == SRC_1BPP && !cfg_refused(cfg)) ? cnt_sat : 4'd1;
		end else if (busy_q && pix_ready) begin
			if (last_pix) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			b_q <= byte_b;
			g_q <= byte_g;
			r_q <= byte_r;
			a_q <= byte_a;
		end
	end

	// msb first
	assign bit_v = b_q[3'd7 - idx_q];
	assign v     = bit_v ? 8'd255 : 8'd0;

	always_comb begin
		pix      = '{b: b_q, g: g_q, r: r_q, a: a_q, last: last_pix};
		if (!cfg_refused(cfg)) begin
			case (cfg.src)
				SRC_1BPP: begin
					pix.b = v;
					pix.g = v;
					pix.r = v;
					pix.a = 8'd0;
				end
				SRC_8BPP: begin
					pix.g = b_q;
					pix.r = b_q;
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pbdc_pipe.sv =====
// three stage datapath: gray products, gray sum, format select
`timescale 1ns / 1ps
`default_nettype none
module pbdc_pipe import pbdc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic pix_valid,
	output logic      pix_ready,
	input  wire pix_t pix,
	output logic      out_valid,
	input  wire logic out_ready,
	output pix_t      out_pix,
	output pipe_stat_t stat
);

	logic        v_s1, v_s2, v_s3;
	logic        en_s1, en_s2, en_s3;
	pix_t        pix_s1, pix_s2, pix_s3;
	logic [21:0] prod_r_s1;
	logic [22:0] prod_g_s1;
	logic [19:0] prod_b_s1;
	logic [22:0] sum_s2;
	logic [7:0]  gray;
	pix_t        sel;

	// each stage moves when its successor has room
	assign en_s3     = !v_s3 || out_ready;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign pix_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pix_s1    <= pix;
			prod_r_s1 <= 22'(pix.r) * 22'(GRAY_KR);
			prod_g_s1 <= 23'(pix.g) * 23'(GRAY_KG);
			prod_b_s1 <= 20'(pix.b) * 20'(GRAY_KB);
		end
		if (en_s2) begin
			pix_s2 <= pix_s1;
			sum_s2 <= 23'(prod_r_s1) + prod_g_s1 + 23'(prod_b_s1);
		end
		if (en_s3) begin
			pix_s3 <= sel;
		end
	end

	assign gray = sum_s2[22:15];

	always_comb begin
		sel = pix_s2;
		if (!cfg_refused(cfg)) begin
			case (cfg.src)
				SRC_1BPP, SRC_8BPP: begin
					sel.a = 8'd0;
					if (cfg.dst == DST_8BPP) begin
						sel.g = 8'd0;
						sel.r = 8'd0;
					end
				end
				SRC_16BPP: begin
					sel.r = 8'd0;
					sel.a = 8'd0;
				end
				SRC_24BPP, SRC_32BPP: begin
					if (cfg.dst == DST_8BPP) begin
						sel.b = gray;
						sel.g = 8'd0;
						sel.r = 8'd0;
						sel.a = 8'd0;
					end else if (cfg.dst == DST_24BPP || cfg.src == SRC_24BPP) begin
						sel.a = 8'd0;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = v_s3;
	assign out_pix   = pix_s3;
	assign stat      = '{v_s1: v_s1, v_s2: v_s2, v_s3: v_s3};

endmodule
`default_nettype wire

// ===== rtl/pixel_bit_depth_converter_unit.sv =====
// top level: pixel bit depth converter with configuration registers
//
// usage
//  - pix_in carries one source pixel, or one packed byte of 1 bpp pixels,
//    per transfer; pix_out carries one target pixel per transfer with last
//    set on the final pixel made from an input item
//  - src_format (index 0) and dst_format (index 1) are written through
//    cfg_we / cfg_index / cfg_data while no item is in flight
//  - path: an input transfer is registered in the front holding stage, then
//    passes the two gray stages and the select stage into the output
//    register that drives pix_out
//  - throughput: one pixel per cycle unless pix_out stalls; a 1 bpp byte
//    stays in the front stage for bit_count pixels (1 to 8), others for one
//  - the front stage takes a new item in the cycle its last pixel moves on
//  - each stage advances whenever the one after it has room, so bubbles
//    are squeezed out and input keeps flowing while a result waits
//  - when the receiver stalls, pix_out holds and the stages fill up;
//    pix_in.ready drops once the front stage cannot move
//  - reset clears all valid bits and loads src_format = 24 bpp,
//    dst_format = 8 bpp
`timescale 1ns / 1ps
`default_nettype none
module pixel_bit_depth_converter_unit import pbdc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [2:0] cfg_data,
	pbdc_in_if.sink         pix_in,
	pbdc_out_if.source      pix_out
);

	cfg_t       cfg_q;
	logic       exp_valid;
	logic       exp_ready;
	pix_t       exp_pix;
	pix_t       res_pix;
	pipe_stat_t stat;

	// configuration registers, written only while idle by the user; the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src <= SRC_24BPP;
			cfg_q.dst <= DST_8BPP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_FORMAT: cfg_q.src <= cfg_data;
				CFG_DST_FORMAT: cfg_q.dst <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// front stage: holds the item, serializes packed 1 bpp bytes
	pbdc_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.byte_b    (pix_in.byte_b),
		.byte_g    (pix_in.byte_g),
		.byte_r    (pix_in.byte_r),
		.byte_a    (pix_in.byte_a),
		.bit_count (pix_in.bit_count),
		.pix_valid (exp_valid),
		.pix_ready (exp_ready),
		.pix       (exp_pix)
	);

	// gray products, gray sum, format select into the output register
	pbdc_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (exp_valid),
		.pix_ready (exp_ready),
		.pix       (exp_pix),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.out_pix   (res_pix),
		.stat      (stat)
	);

	assign pix_out.out_b = res_pix.b;
	assign pix_out.out_g = res_pix.g;
	assign pix_out.out_r = res_pix.r;
	assign pix_out.out_a = res_pix.a;
	assign pix_out.last  = res_pix.last;

	// no new item while the front stage still owes pixels of the current one
	a_no_take_midbyte: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid && !exp_pix.last |-> !pix_in.ready)
		else $error("input taken while front stage still expanding");

	// a full, stalled pipe must back-pressure a busy front stage
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stat.v_s1 && stat.v_s2 && stat.v_s3 && !pix_out.ready && exp_valid
		|-> !pix_in.ready)
		else $error("input taken while pipeline full and stalled");

	// a stalled front pixel stays pending into the next cycle
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid && !exp_ready |=> exp_valid)
		else $error("front stage pixel dropped under stall");

endmodule
`default_nettype wire
